// ----- sv/splt_pkg.sv -----
package splt_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgCoefA = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCoefB = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCoefC = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     final_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [CoordW-1:0] sorted_x;
    logic signed [CoordW-1:0] sorted_y;
    logic                     final_result;
  } out_beat_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

endpackage

// ----- sv/splt_key_unit.sv -----
// two-stage key pipeline: products registered, then sum and magnitude
module splt_key_unit (
  input  logic                                 clk_i,
  input  logic signed [splt_pkg::CoordW-1:0]   coef_a_i,
  input  logic signed [splt_pkg::CoordW-1:0]   coef_b_i,
  input  logic signed [splt_pkg::CoordW-1:0]   coef_c_i,
  input  splt_pkg::point_t                     pt_i,
  output logic        [splt_pkg::KeyW-1:0]     key_o
);

  logic signed [31:0] pa_q, pb_q;
  logic signed [33:0] sum;

  always_ff @(posedge clk_i) begin
    pa_q <= 32'(coef_a_i) * 32'(pt_i.x);
    pb_q <= 32'(coef_b_i) * 32'(pt_i.y);
  end

  always_comb begin
    sum = 34'(pa_q) + 34'(pb_q) + 34'(coef_c_i);
    if (sum < 0) begin
      key_o = splt_pkg::KeyW'(-sum);
    end else begin
      key_o = splt_pkg::KeyW'(sum);
    end
  end

endmodule

// ----- sv/splt_core.sv -----
// sequencer over point and key memories, in-place stable insertion sort
module splt_core #(
  parameter int unsigned MaxPoints = splt_pkg::MaxPoints
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [splt_pkg::CoordW-1:0] coef_a_i,
  input  logic signed [splt_pkg::CoordW-1:0] coef_b_i,
  input  logic signed [splt_pkg::CoordW-1:0] coef_c_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  splt_pkg::in_beat_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output splt_pkg::out_beat_t                out_data_o
);

  localparam int unsigned AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CW = $clog2(MaxPoints + 1);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StKey  = 3'd1;  // issue key reads
  localparam logic [2:0] StPick = 3'd2;  // read element i
  localparam logic [2:0] StCmp  = 3'd3;  // read j-1, compare, shift
  localparam logic [2:0] StIns  = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  splt_pkg::point_t        pmem [MaxPoints];
  logic [splt_pkg::KeyW-1:0] kmem [MaxPoints];

  logic [2:0]  st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [AW-1:0] raddr;
  logic          rd_en;
  splt_pkg::point_t         prd_q, hold_p_q, hold_p_d;
  logic [splt_pkg::KeyW-1:0] krd_q, hold_k_q, hold_k_d, key;
  logic        pwe, kwe;
  logic [AW-1:0] pwa, kwa;
  splt_pkg::point_t pwd;
  logic [splt_pkg::KeyW-1:0] kwd;
  logic [1:0]  kv_q;       // key pipeline valid: read, product
  logic [AW-1:0] ka0_q, ka1_q;
  logic [CW-1:0] kissue_q, kissue_d;
  logic        rd_pend_q;  // pick/cmp/emit read returned next cycle
  logic        emit_pend_q, emit_pend_d;
  logic        ov_q, ov_d;
  splt_pkg::out_beat_t od_q, od_d;
  logic [CW-1:0] ecnt_q, ecnt_d;

  splt_key_unit u_key (
    .clk_i, .coef_a_i, .coef_b_i, .coef_c_i, .pt_i(prd_q), .key_o(key)
  );

  always_ff @(posedge clk_i) begin
    if (pwe) pmem[pwa] <= pwd;
    if (kwe) kmem[kwa] <= kwd;
    if (rd_en) begin
      prd_q <= pmem[raddr];
      krd_q <= kmem[raddr];
    end
  end

  assign in_stall_o  = (st_q != StLoad);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q;
    hold_p_d = hold_p_q; hold_k_d = hold_k_q;
    kissue_d = kissue_q; emit_pend_d = emit_pend_q;
    ov_d = ov_q; od_d = od_q; ecnt_d = ecnt_q;
    pwe = 1'b0; kwe = 1'b0; pwa = '0; kwa = '0; pwd = '0; kwd = '0;
    rd_en = 1'b0; raddr = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      StLoad: begin
        if (in_valid_i) begin
          if (cnt_q < CW'(MaxPoints)) begin
            pwe = 1'b1; pwa = AW'(cnt_q);
            pwd.x = in_data_i.point_x; pwd.y = in_data_i.point_y;
            cnt_d = cnt_q + 1'b1;
          end
          if (in_data_i.final_point) begin
            st_d = StKey; kissue_d = '0;
          end
        end
      end
      StKey: begin
        if (kissue_q < cnt_q) begin
          rd_en = 1'b1; raddr = AW'(kissue_q); kissue_d = kissue_q + 1'b1;
        end
        if (kv_q[1]) begin
          kwe = 1'b1; kwa = ka1_q; kwd = key;
          if (ka1_q == AW'(cnt_q - 1'b1)) begin
            st_d = StPick; i_d = CW'(1);
          end
        end
      end
      StPick: begin
        if (i_q >= cnt_q) begin
          st_d = StEmit; ecnt_d = '0; emit_pend_d = 1'b0;
        end else if (!rd_pend_q) begin
          rd_en = 1'b1; raddr = AW'(i_q);
        end else begin
          hold_p_d = prd_q; hold_k_d = krd_q;
          j_d = i_q; st_d = StCmp;
          rd_en = 1'b1; raddr = AW'(i_q - 1'b1);
        end
      end
      StCmp: begin
        if (rd_pend_q) begin
          if (krd_q > hold_k_q) begin
            pwe = 1'b1; kwe = 1'b1; pwa = AW'(j_q); kwa = AW'(j_q);
            pwd = prd_q; kwd = krd_q;
            j_d = j_q - 1'b1;
            if (j_q == CW'(1)) st_d = StIns;
            else begin
              rd_en = 1'b1; raddr = AW'(j_q - 2'd2);
            end
          end else st_d = StIns;
        end
      end
      StIns: begin
        pwe = 1'b1; kwe = 1'b1; pwa = AW'(j_q); kwa = AW'(j_q);
        pwd = hold_p_q; kwd = hold_k_q;
        i_d = i_q + 1'b1; st_d = StPick;
      end
      StEmit: begin
        if (emit_pend_q && (!ov_q || !out_stall_i)) begin
          ov_d = 1'b1;
          od_d.sorted_x = prd_q.x; od_d.sorted_y = prd_q.y;
          od_d.final_result = (ecnt_q + 1'b1 == cnt_q);
          emit_pend_d = 1'b0; ecnt_d = ecnt_q + 1'b1;
          if (ecnt_q + 1'b1 == cnt_q) begin
            st_d = StLoad; cnt_d = '0;
          end
        end else if (!emit_pend_q && !rd_pend_q && ecnt_q < cnt_q) begin
          rd_en = 1'b1; raddr = AW'(ecnt_q);
        end
        if (rd_pend_q) emit_pend_d = 1'b1;
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; cnt_q <= '0; i_q <= '0; j_q <= '0;
      kissue_q <= '0; kv_q <= '0; rd_pend_q <= 1'b0;
      emit_pend_q <= 1'b0; ov_q <= 1'b0; ecnt_q <= '0;
      ka0_q <= '0; ka1_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; j_q <= j_d;
      kissue_q <= kissue_d; emit_pend_q <= emit_pend_d;
      ov_q <= ov_d; ecnt_q <= ecnt_d;
      rd_pend_q <= rd_en && (st_q != StKey);
      kv_q <= {kv_q[0], rd_en && (st_q == StKey)};
      ka0_q <= raddr; ka1_q <= ka0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_p_q <= hold_p_d; hold_k_q <= hold_k_d; od_q <= od_d;
  end

endmodule

// ----- sv/sort_points_by_line_distance_top.sv -----
// channel | direction | handshake                | beat
// in      | input     | in_valid_i/in_stall_o    | point_x, point_y, final_point
// out     | output    | out_valid_o/out_stall_i  | sorted_x, sorted_y, final_result
// cfg     | input     | cfg_we_i                 | coef_a, coef_b, coef_c
// loading accepts one point per cycle; the final point starts the sort
// key pass: each point is read from the point memory, passes the key pipeline, key written back
// sort: in-place insertion; per point a pick, a compare-and-shift step per shifted entry, an insert
// emit: each result is read, then registered out; stalls on the out side hold the sequencer
// reset clears control and restores coefficients; memories are not cleared
module sort_points_by_line_distance_top #(
  parameter int unsigned MaxPoints = splt_pkg::MaxPoints
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [splt_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [splt_pkg::CoordW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  splt_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output splt_pkg::out_beat_t                 out_data_o
);

  // line coefficients
  logic signed [splt_pkg::CoordW-1:0] coef_a_q, coef_b_q, coef_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= '0;
      coef_b_q <= splt_pkg::CoordW'(1);
      coef_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        splt_pkg::CfgCoefA: coef_a_q <= cfg_data_i;
        splt_pkg::CfgCoefB: coef_b_q <= cfg_data_i;
        splt_pkg::CfgCoefC: coef_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer plus memories
  splt_core #(.MaxPoints(MaxPoints)) u_core (
    .clk_i, .rst_ni,
    .coef_a_i(coef_a_q), .coef_b_i(coef_b_q), .coef_c_i(coef_c_q),
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
